// ===== sv/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg - shared definitions for the ARP responder and resolver
// Opcodes, status codes, register indexes and the scan result record.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  // Default depth of the pending resolve table.
  localparam int PENDING_ENTRIES_DEF = 8;

  // ARP opcodes as carried in the packet.
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  // Opcodes as carried in the two-bit result field.
  localparam logic [1:0] FOP_NONE    = 2'd0;
  localparam logic [1:0] FOP_REQUEST = 2'd1;
  localparam logic [1:0] FOP_REPLY   = 2'd2;

  // Protocol address length of IPv4.
  localparam logic [7:0] IPV4_LEN = 8'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NOT_FOR_US    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED   = 2'd2;
  localparam logic [1:0] ST_INSERT_FAILED = 2'd3;

  // Input item kind.
  localparam logic ACT_PACKET  = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_IP       = 2'd0;
  localparam logic [1:0] CFG_OWN_IP_VALID = 2'd1;
  localparam logic [1:0] CFG_OWN_MAC      = 2'd2;

  // Flags reported by the scan unit after a full walk of the table.
  typedef struct packed {
    logic hit;      // a used entry holds the key
    logic free_ok;  // at least one entry is free
  } scan_res_t;

endpackage

`default_nettype wire

// ===== sv/arp_responder_resolver.sv =====
// ----------------------------------------------------------------------------
// arp_responder_resolver - ARP responder and resolver for IPv4 over Ethernet
// Answers ARP requests for the own address, learns replies to pending
// resolves and issues request frames for new resolves.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Content
//   in_      slave      in_tvalid/in_tready   one ARP packet or resolve
//   out_     master     out_tvalid/out_tready one result per input item
//   cfg_     slave      cfg_valid/cfg_ready   register index and write data
//
// A resolve or a reply with IPv4 length walks all PENDING_ENTRIES entries, one
// per cycle through the table's read port and the shared compare unit; the
// decision step registers its result after the walk and the wait state. Other
// packets skip the walk and go straight to the decision step. No new item is
// taken before the sequencer is back in idle: in_tready is high only when idle,
// and only the decision step holds while the output register is full.
// Reset is synchronous, active low, and clears all used flags at once.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder_resolver
  import arp_pkg::*;
#(
  parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input item.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata fields from bit 0 up: opcode[15:0], proto_len[23:16],
  // sender_mac[71:24], sender_ip[103:72], target_ip[135:104].
  input  wire logic [135:0] in_tdata,
  // tuser fields from bit 0 up: action[0].
  input  wire logic         in_tuser,
  // Result item.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata fields from bit 0 up: status[1:0], send_frame[2],
  // frame_opcode[4:3], frame_sender_ip[36:5], frame_target_mac[84:37],
  // frame_target_ip[116:85], learned[117], learned_mac[165:118],
  // learned_ip[197:166], zero fill[199:198].
  output logic [199:0]      out_tdata,
  // Configuration writes.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);

  localparam int IDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PENDING_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration. The station MAC only goes into assembled frames, which
  // are built downstream, so a write to it is taken and not stored.
  logic [31:0] own_ip_r;
  logic        own_ip_vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r     <= '0;
      own_ip_vld_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_IP:       own_ip_r     <= cfg_data[31:0];
        CFG_OWN_IP_VALID: own_ip_vld_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic        act_r;
  logic [15:0] opcode_r;
  logic [7:0]  plen_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] tip_r;

  logic in_xfer;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r    <= in_tuser;
      opcode_r <= in_tdata[15:0];
      plen_r   <= in_tdata[23:16];
      smac_r   <= in_tdata[71:24];
      sip_r    <= in_tdata[103:72];
      tip_r    <= in_tdata[135:104];
    end
  end

  // A resolve looks up its target, a reply with IPv4 length its sender.
  logic        need_scan_in;
  logic        is_reply;
  logic [31:0] key;

  assign need_scan_in = (in_tuser == ACT_RESOLVE) ||
                        ((in_tdata[15:0] == OP_REPLY) && (in_tdata[23:16] == IPV4_LEN));
  assign is_reply     = (opcode_r == OP_REPLY) && (plen_r == IPV4_LEN);
  assign key          = (act_r == ACT_RESOLVE) ? tip_r : sip_r;

  // Walk counter driving the table read port.
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             rd_en;

  assign rd_en = (state_r == S_SCAN);

  // Table and compare unit.
  logic             tb_vld, tb_used;
  logic [IDX_W-1:0] tb_idx;
  logic [31:0]      tb_addr;
  logic             ins_en, clr_en;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] hit_idx, free_idx;

  arp_pend_table #(
    .ENTRIES (PENDING_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_idx    (cnt_r),
    .rd_vld_r  (tb_vld),
    .rd_idx_r  (tb_idx),
    .rd_used_r (tb_used),
    .rd_addr_r (tb_addr),
    .ins_en    (ins_en),
    .ins_idx   (free_idx),
    .ins_addr  (tip_r),
    .clr_en    (clr_en),
    .clr_idx   (hit_idx)
  );

  arp_scan_unit #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .key       (key),
    .beat_vld  (tb_vld),
    .beat_idx  (tb_idx),
    .beat_used (tb_used),
    .beat_addr (tb_addr),
    .res       (scan_res),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  // Decision step. It runs once the output register can take the result.
  logic         out_vld_r, out_vld_nxt;
  logic [197:0] res_data;
  logic [1:0]   r_status;
  logic         r_send;
  logic [1:0]   r_fop;
  logic [31:0]  r_fsip;
  logic [47:0]  r_ftmac;
  logic [31:0]  r_ftip;
  logic         r_learn;
  logic [47:0]  r_lmac;
  logic [31:0]  r_lip;
  logic         decide;

  assign decide = (state_r == S_DONE) && (!out_vld_r || out_tready);

  always_comb begin
    r_status = ST_OK;
    r_send   = 1'b0;
    r_fop    = FOP_NONE;
    r_fsip   = '0;
    r_ftmac  = '0;
    r_ftip   = '0;
    r_learn  = 1'b0;
    r_lmac   = '0;
    r_lip    = '0;
    ins_en   = 1'b0;
    clr_en   = 1'b0;
    if (act_r == ACT_RESOLVE) begin
      if (scan_res.hit || !scan_res.free_ok) begin
        r_status = ST_INSERT_FAILED;
      end else begin
        r_send = 1'b1;
        r_fop  = FOP_REQUEST;
        r_ftip = tip_r;
        ins_en = decide;
      end
    end else if (opcode_r == OP_REQUEST) begin
      // The protocol length of a request is not checked.
      if (!own_ip_vld_r || (own_ip_r != tip_r)) begin
        r_status = ST_NOT_FOR_US;
      end else begin
        r_send  = 1'b1;
        r_fop   = FOP_REPLY;
        r_fsip  = own_ip_r;
        r_ftmac = smac_r;
        r_ftip  = sip_r;
      end
    end else if (is_reply) begin
      // A reply that matches no pending entry is accepted silently.
      if (scan_res.hit) begin
        r_learn = 1'b1;
        r_lmac  = smac_r;
        r_lip   = sip_r;
        clr_en  = decide;
      end
    end else begin
      r_status = ST_UNSUPPORTED;
    end
  end

  assign res_data = {r_lip, r_lmac, r_learn, r_ftip, r_ftmac, r_fsip, r_fop,
                     r_send, r_status};

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          state_nxt = need_scan_in ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        // The last entry's data reaches the compare unit in this cycle.
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (decide) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (decide) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  logic [197:0] out_data_r;

  always_ff @(posedge clk) begin
    if (decide) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

`default_nettype wire

// ===== sv/arp_pend_table.sv =====
// ----------------------------------------------------------------------------
// arp_pend_table - pending resolve table
// Address memory with a registered read port, plus per-entry used flags.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_pend_table
  import arp_pkg::*;
#(
  parameter int ENTRIES = PENDING_ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic                  rd_vld_r,
  output logic [IDX_W-1:0]      rd_idx_r,
  output logic                  rd_used_r,
  output logic [31:0]           rd_addr_r,
  input  wire logic             ins_en,
  input  wire logic [IDX_W-1:0] ins_idx,
  input  wire logic [31:0]      ins_addr,
  input  wire logic             clr_en,
  input  wire logic [IDX_W-1:0] clr_idx
);

  logic [31:0]        addr_mem [ENTRIES];
  logic [ENTRIES-1:0] used_r;

  always_ff @(posedge clk) begin
    if (ins_en) begin
      addr_mem[ins_idx] <= ins_addr;
    end
    rd_addr_r <= addr_mem[rd_idx];
    rd_idx_r  <= rd_idx;
    rd_used_r <= used_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (ins_en) begin
        used_r[ins_idx] <= 1'b1;
      end
      if (clr_en) begin
        used_r[clr_idx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/arp_scan_unit.sv =====
// ----------------------------------------------------------------------------
// arp_scan_unit - shared compare unit for the table walk
// Takes one table entry per cycle and keeps the first key match and the
// lowest free entry seen since the last start.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_scan_unit
  import arp_pkg::*;
#(
  parameter int IDX_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      key,
  input  wire logic             beat_vld,
  input  wire logic [IDX_W-1:0] beat_idx,
  input  wire logic             beat_used,
  input  wire logic [31:0]      beat_addr,
  output scan_res_t             res,
  output logic [IDX_W-1:0]      hit_idx,
  output logic [IDX_W-1:0]      free_idx
);

  logic             hit_r, hit_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  always_comb begin
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    if (start) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (beat_vld) begin
      if (beat_used && (beat_addr == key) && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = beat_idx;
      end
      if (!beat_used && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = beat_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign res.hit     = hit_r;
  assign res.free_ok = free_r;
  assign hit_idx     = hit_idx_r;
  assign free_idx    = free_idx_r;

endmodule

`default_nettype wire
